// ===== sv/srpt_pkg.sv =====
// Shared types, constants and helpers for the sinusoidal rigid point transform.
// No dependencies; imported by the top level, front, queue, CORDIC, back end and testbench files.
package srpt_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam int FRAC_BITS    = 16;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int MUL_W  = 34;
   localparam int PROD_W = 2 * MUL_W;
   localparam int RND_W  = PROD_W - 30;

   localparam logic signed [MUL_W-1:0]  ONE_Q30     = MUL_W'(64'sd1 << 30);
   localparam logic signed [PROD_W-1:0] HALF_Q30    = PROD_W'(64'sd1 << 29);
   localparam logic signed [MUL_W-1:0]  CORDIC_GAIN = MUL_W'(64'sd652032874);
   localparam logic signed [MUL_W-1:0]  INV_TWO_PI  = MUL_W'(64'sd683565276);

   localparam logic [31:0] ATAN_TURNS [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
   };

   typedef enum logic [2:0] {
      CSR_ROT_AMPLITUDE, CSR_ROT_FREQUENCY, CSR_TRANS_AMPLITUDE, CSR_TRANS_FREQUENCY,
      CSR_DIRECTION_XY, CSR_ORIGIN_XY, CSR_PHASE_PAIR, CSR_SMOOTH_START
   } csr_index_type;

   typedef enum logic {KIND_TIME, KIND_POINT} kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [31:0]        time_value;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [31:0] pz;
   } item_type;

   typedef struct packed {
      logic [17:0]        rot_amplitude;
      logic [31:0]        rot_frequency;
      logic [30:0]        trans_amplitude;
      logic [31:0]        trans_frequency;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic [15:0]        phase_t;
      logic [15:0]        phase_e;
      logic               smooth_start;
   } cfg_type;

   typedef struct packed {
      logic        start;
      logic [31:0] turn;
   } cordic_req_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] cosine;
      logic signed [31:0] sine;
   } cordic_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_W_MUL, ST_W_CHK, ST_W_RAMP, ST_W_SIN_GO, ST_W_SIN, ST_W_M1, ST_W_M2,
      ST_A_TURN, ST_A_CS_GO, ST_A_CS, ST_T_MX, ST_T_MY, ST_T_END,
      ST_P_M2, ST_P_M3, ST_P_M4, ST_P_FIN, ST_DONE
   } back_state_type;

   // round half up and drop 30 fraction bits
   function automatic logic signed [RND_W-1:0] rnd30(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] t;
      t = p + HALF_Q30;
      return RND_W'(t >>> 30);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [RND_W-1:0] v);
      if (v > RND_W'(64'sd2147483647)) return 32'sh7FFF_FFFF;
      else if (v < -RND_W'(64'sd2147483648)) return 32'sh8000_0000;
      else return 32'(v);
   endfunction

endpackage

// ===== sv/srpt_ifs.sv =====
// Valid/ready channel interfaces for request and response words.
// Depends on nothing.
interface srpt_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic [31:0]        time_value;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;
   modport source (output valid, mode, time_value, point_x, point_y, point_z, input ready);
   modport sink   (input valid, mode, time_value, point_x, point_y, point_z, output ready);
endinterface

interface srpt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] angle;
   logic signed [31:0] shift_x;
   logic signed [31:0] shift_y;
   modport source (output valid, pos_x, pos_y, pos_z, angle, shift_x, shift_y, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, angle, shift_x, shift_y, output ready);
endinterface

// ===== sv/sinusoidal_rigid_point_transform.sv =====
// Top level of the sinusoidal rigid point transform: register file and block wiring.
// Depends on srpt_pkg, srpt_ifs, srpt_front, srpt_queue and srpt_back.
//
//   channel   direction  word carries
//   req_chan  in         mode, time_value, point_x, point_y, point_z
//   rsp_chan  out        pos_x, pos_y, pos_z, angle, shift_x, shift_y
//   csr_*     in         write enable, register index, 64-bit write data
//
// In the back end a point word makes four products through the one shared
// 34x34 multiplier, then the output load. A time word is set by up to five
// CORDIC runs in series. Reset is synchronous; it returns the kept angle,
// cos/sin and shift and the registers to their defaults. Either side may
// stall: the front stage and a two-word queue keep taking words while the
// back end works or a response waits.
module sinusoidal_rigid_point_transform (
   input  logic        clock,
   input  logic        reset,
   srpt_req_if.sink    req_chan,
   srpt_rsp_if.source  rsp_chan,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_write_data
);
   import srpt_pkg::*;

   cfg_type  cfg_ff;
   logic     push_valid, push_ready, pop_valid, pop_ready;
   item_type push_item, pop_item;

   // register file: write only, one register per index
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{rot_amplitude: 18'd0, rot_frequency: 32'd65536,
                     trans_amplitude: 31'd0, trans_frequency: 32'd65536,
                     dir_x: 32'sh4000_0000, dir_y: 32'sd0,
                     origin_x: 32'sd0, origin_y: 32'sd0,
                     phase_t: 16'd0, phase_e: 16'd0, smooth_start: 1'b0};
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROT_AMPLITUDE:   cfg_ff.rot_amplitude   <= csr_write_data[17:0];
            CSR_ROT_FREQUENCY:   cfg_ff.rot_frequency   <= csr_write_data[31:0];
            CSR_TRANS_AMPLITUDE: cfg_ff.trans_amplitude <= csr_write_data[30:0];
            CSR_TRANS_FREQUENCY: cfg_ff.trans_frequency <= csr_write_data[31:0];
            CSR_DIRECTION_XY: begin
               cfg_ff.dir_x <= csr_write_data[31:0];
               cfg_ff.dir_y <= csr_write_data[63:32];
            end
            CSR_ORIGIN_XY: begin
               cfg_ff.origin_x <= csr_write_data[31:0];
               cfg_ff.origin_y <= csr_write_data[63:32];
            end
            CSR_PHASE_PAIR: begin
               cfg_ff.phase_t <= csr_write_data[15:0];
               cfg_ff.phase_e <= csr_write_data[31:16];
            end
            CSR_SMOOTH_START:    cfg_ff.smooth_start    <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // classify and hold incoming words
   srpt_front u_front (
      .clock(clock), .reset(reset), .req(req_chan), .cfg(cfg_ff),
      .push_valid(push_valid), .push_item(push_item), .push_ready(push_ready)
   );

   // decouple front and back
   srpt_queue u_queue (
      .clock(clock), .reset(reset),
      .push_valid(push_valid), .push_item(push_item), .push_ready(push_ready),
      .pop_valid(pop_valid), .pop_item(pop_item), .pop_ready(pop_ready)
   );

   // advance the transform and drive the response register
   srpt_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .pop_valid(pop_valid), .pop_item(pop_item), .pop_ready(pop_ready),
      .rsp(rsp_chan)
   );
endmodule

// ===== sv/srpt_front.sv =====
// Front end: takes request words, classifies them and prepares point offsets.
// Depends on srpt_pkg and srpt_ifs.
module srpt_front (
   input  logic              clock,
   input  logic              reset,
   srpt_req_if.sink          req,
   input  srpt_pkg::cfg_type cfg,
   output logic              push_valid,
   output srpt_pkg::item_type push_item,
   input  logic              push_ready
);
   import srpt_pkg::*;

   logic     full_ff, full_in;
   item_type entry_ff, entry_in;

   assign req.ready  = !full_ff || push_ready;
   assign push_valid = full_ff;
   assign push_item  = entry_ff;

   always_comb begin
      full_in  = full_ff;
      entry_in = entry_ff;
      if (full_ff && push_ready) full_in = 1'b0;
      if (req.valid && req.ready) begin
         full_in             = 1'b1;
         entry_in.kind       = req.mode ? KIND_POINT : KIND_TIME;
         entry_in.time_value = req.time_value;
         entry_in.dx         = 33'(req.point_x) - 33'(cfg.origin_x);
         entry_in.dy         = 33'(req.point_y) - 33'(cfg.origin_y);
         entry_in.pz         = req.point_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) full_ff <= 1'b0;
      else full_ff <= full_in;
      entry_ff <= entry_in;
   end
endmodule

// ===== sv/srpt_queue.sv =====
// Short queue between front and back end.
// Depends on srpt_pkg.
module srpt_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  srpt_pkg::item_type push_item,
   output logic               push_ready,
   output logic               pop_valid,
   output srpt_pkg::item_type pop_item,
   input  logic               pop_ready
);
   import srpt_pkg::*;

   item_type           mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ff, rd_ff;
   logic [QCNT_W-1:0]  count_ff;
   logic               do_push, do_pop;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = mem[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) wr_ff <= (wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         if (do_pop)  rd_ff <= (rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         count_ff <= count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
      end
      if (do_push) mem[wr_ff] <= push_item;
   end
endmodule

// ===== sv/srpt_cordic.sv =====
// Iterative rotation-mode CORDIC over turn angles, one step per cycle.
// Depends on srpt_pkg.
module srpt_cordic (
   input  logic                      clock,
   input  logic                      reset,
   input  srpt_pkg::cordic_req_type  creq,
   output srpt_pkg::cordic_rsp_type  crsp
);
   import srpt_pkg::*;

   logic                    busy_ff, done_ff, flip_ff;
   logic [STEP_W-1:0]       step_ff;
   logic signed [MUL_W-1:0] x_ff, y_ff, z_ff, x_nx, y_nx, z_nx, z0;
   logic signed [31:0]      cos_ff, sin_ff;
   logic [4:0]              k;

   function automatic logic signed [MUL_W-1:0] clamp(input logic signed [MUL_W-1:0] v);
      if (v > ONE_Q30) return ONE_Q30;
      else if (v < -ONE_Q30) return -ONE_Q30;
      else return v;
   endfunction

   assign k    = 5'(step_ff);
   assign z0   = MUL_W'(signed'(creq.turn));
   assign crsp = '{done: done_ff, cosine: cos_ff, sine: sin_ff};

   always_comb begin
      if (z_ff >= 0) begin
         x_nx = x_ff - (y_ff >>> k);
         y_nx = y_ff + (x_ff >>> k);
         z_nx = z_ff - MUL_W'(ATAN_TURNS[k]);
      end else begin
         x_nx = x_ff + (y_ff >>> k);
         y_nx = y_ff - (x_ff >>> k);
         z_nx = z_ff + MUL_W'(ATAN_TURNS[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (creq.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (creq.start) begin
         step_ff <= '0;
         x_ff    <= CORDIC_GAIN;
         y_ff    <= '0;
         if (z0 > ONE_Q30 || z0 < -ONE_Q30) begin
            z_ff    <= MUL_W'(signed'(creq.turn ^ 32'h8000_0000));
            flip_ff <= 1'b1;
         end else begin
            z_ff    <= z0;
            flip_ff <= 1'b0;
         end
      end else if (busy_ff) begin
         step_ff <= step_ff + 1'b1;
         x_ff    <= x_nx;
         y_ff    <= y_nx;
         z_ff    <= z_nx;
         if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
            cos_ff <= 32'(flip_ff ? -clamp(x_nx) : clamp(x_nx));
            sin_ff <= 32'(flip_ff ? -clamp(y_nx) : clamp(y_nx));
         end
      end
   end
endmodule

// ===== sv/srpt_back.sv =====
// Back end: sequencer with one shared multiplier and the CORDIC unit.
// Depends on srpt_pkg, srpt_ifs and srpt_cordic.
module srpt_back (
   input  logic               clock,
   input  logic               reset,
   input  srpt_pkg::cfg_type  cfg,
   input  logic               pop_valid,
   input  srpt_pkg::item_type pop_item,
   output logic               pop_ready,
   srpt_rsp_if.source         rsp
);
   import srpt_pkg::*;

   back_state_type           state_ff, state_in;
   logic                     trans_ff, trans_in;
   item_type                 item_ff, item_in;
   logic signed [MUL_W-1:0]  mul_a, mul_b, mag_ff, mag_in;
   logic signed [PROD_W-1:0] mul_ff, acc_ff, acc_in;
   logic [31:0]              frac_ff, frac_in;
   logic signed [31:0]       ramp_ff, ramp_in;
   logic signed [RND_W-1:0]  rx_ff, rx_in, ry_ff, ry_in;
   logic signed [31:0]       angle_ff, angle_in, cos_ff, cos_in, sin_ff, sin_in;
   logic signed [31:0]       shx_ff, shx_in, shy_ff, shy_in;
   logic                     out_valid_ff, out_valid_in, load;
   logic signed [31:0]       px_ff, py_ff, pz_ff;
   logic signed [31:0]       ang_out_ff, shx_out_ff, shy_out_ff;
   logic [63:0]              wave_p;
   cordic_req_type           creq;
   cordic_rsp_type           crsp;

   srpt_cordic u_cordic (.clock(clock), .reset(reset), .creq(creq), .crsp(crsp));

   assign wave_p      = mul_ff[63:0];
   assign rsp.valid   = out_valid_ff;
   assign rsp.pos_x   = px_ff;
   assign rsp.pos_y   = py_ff;
   assign rsp.pos_z   = pz_ff;
   assign rsp.angle   = ang_out_ff;
   assign rsp.shift_x = shx_out_ff;
   assign rsp.shift_y = shy_out_ff;

   always_comb begin
      state_in  = state_ff;
      trans_in  = trans_ff;
      item_in   = item_ff;
      mag_in    = mag_ff;
      acc_in    = acc_ff;
      frac_in   = frac_ff;
      ramp_in   = ramp_ff;
      rx_in     = rx_ff;
      ry_in     = ry_ff;
      angle_in  = angle_ff;
      cos_in    = cos_ff;
      sin_in    = sin_ff;
      shx_in    = shx_ff;
      shy_in    = shy_ff;
      mul_a     = '0;
      mul_b     = '0;
      creq      = '{start: 1'b0, turn: 32'd0};
      pop_ready = 1'b0;
      load      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               pop_ready = 1'b1;
               item_in   = pop_item;
               trans_in  = 1'b0;
               mul_a     = MUL_W'(cos_ff);
               mul_b     = MUL_W'(pop_item.dx);
               state_in  = (pop_item.kind == KIND_POINT) ? ST_P_M2 : ST_W_MUL;
            end
         end
         ST_W_MUL: begin
            mul_a    = signed'(MUL_W'(trans_ff ? cfg.trans_frequency : cfg.rot_frequency));
            mul_b    = signed'(MUL_W'(item_ff.time_value));
            state_in = ST_W_CHK;
         end
         ST_W_CHK: begin
            frac_in = 32'((wave_p << (64 - 2 * FRAC_BITS)) >> 32);
            if (cfg.smooth_start && (wave_p >> (2 * FRAC_BITS)) == 64'd0) begin
               creq     = '{start: 1'b1, turn: frac_in >> 1};
               state_in = ST_W_RAMP;
            end else begin
               ramp_in  = 32'(ONE_Q30);
               state_in = ST_W_SIN_GO;
            end
         end
         ST_W_RAMP: begin
            if (crsp.done) begin
               ramp_in  = 32'((ONE_Q30 - MUL_W'(crsp.cosine)) >>> 1);
               state_in = ST_W_SIN_GO;
            end
         end
         ST_W_SIN_GO: begin
            creq.start = 1'b1;
            creq.turn  = frac_ff + {cfg.phase_t, 16'd0}
                       + (trans_ff ? 32'd0 : {cfg.phase_e, 16'd0});
            state_in   = ST_W_SIN;
         end
         ST_W_SIN: begin
            if (crsp.done) begin
               mul_a    = trans_ff ? signed'(MUL_W'(cfg.trans_amplitude))
                                   : signed'(MUL_W'(cfg.rot_amplitude));
               mul_b    = MUL_W'(crsp.sine);
               state_in = ST_W_M1;
            end
         end
         ST_W_M1: begin
            mul_a    = MUL_W'(rnd30(mul_ff));
            mul_b    = MUL_W'(ramp_ff);
            state_in = ST_W_M2;
         end
         ST_W_M2: begin
            if (trans_ff) begin
               mag_in   = MUL_W'(rnd30(mul_ff));
               state_in = ST_T_MX;
            end else begin
               angle_in = sat32(rnd30(mul_ff));
               state_in = ST_A_TURN;
            end
         end
         ST_A_TURN: begin
            mul_a    = MUL_W'(angle_ff);
            mul_b    = INV_TWO_PI;
            state_in = ST_A_CS_GO;
         end
         ST_A_CS_GO: begin
            creq     = '{start: 1'b1, turn: 32'(mul_ff >>> FRAC_BITS)};
            state_in = ST_A_CS;
         end
         ST_A_CS: begin
            if (crsp.done) begin
               cos_in   = crsp.cosine;
               sin_in   = crsp.sine;
               trans_in = 1'b1;
               state_in = ST_W_MUL;
            end
         end
         ST_T_MX: begin
            mul_a    = mag_ff;
            mul_b    = MUL_W'(cfg.dir_x);
            state_in = ST_T_MY;
         end
         ST_T_MY: begin
            shx_in   = sat32(rnd30(mul_ff));
            mul_a    = mag_ff;
            mul_b    = MUL_W'(cfg.dir_y);
            state_in = ST_T_END;
         end
         ST_T_END: begin
            shy_in   = sat32(rnd30(mul_ff));
            state_in = ST_DONE;
         end
         ST_P_M2: begin
            acc_in   = mul_ff;
            mul_a    = MUL_W'(sin_ff);
            mul_b    = MUL_W'(item_ff.dy);
            state_in = ST_P_M3;
         end
         ST_P_M3: begin
            rx_in    = rnd30(acc_ff - mul_ff);
            mul_a    = MUL_W'(sin_ff);
            mul_b    = MUL_W'(item_ff.dx);
            state_in = ST_P_M4;
         end
         ST_P_M4: begin
            acc_in   = mul_ff;
            mul_a    = MUL_W'(cos_ff);
            mul_b    = MUL_W'(item_ff.dy);
            state_in = ST_P_FIN;
         end
         ST_P_FIN: begin
            ry_in    = rnd30(acc_ff + mul_ff);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp.ready) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      out_valid_in = load || (out_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         angle_ff     <= '0;
         cos_ff       <= 32'(ONE_Q30);
         sin_ff       <= '0;
         shx_ff       <= '0;
         shy_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         angle_ff     <= angle_in;
         cos_ff       <= cos_in;
         sin_ff       <= sin_in;
         shx_ff       <= shx_in;
         shy_ff       <= shy_in;
      end
      trans_ff <= trans_in;
      item_ff  <= item_in;
      mul_ff   <= mul_a * mul_b;
      mag_ff   <= mag_in;
      acc_ff   <= acc_in;
      frac_ff  <= frac_in;
      ramp_ff  <= ramp_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      if (load) begin
         // hold a copy of the kept motion so a stalled word stays put
         ang_out_ff <= angle_ff;
         shx_out_ff <= shx_ff;
         shy_out_ff <= shy_ff;
         if (item_ff.kind == KIND_POINT) begin
            px_ff <= sat32(rx_ff + RND_W'(cfg.origin_x) + RND_W'(shx_ff));
            py_ff <= sat32(ry_ff + RND_W'(cfg.origin_y) + RND_W'(shy_ff));
            pz_ff <= item_ff.pz;
         end else begin
            px_ff <= '0;
            py_ff <= '0;
            pz_ff <= '0;
         end
      end
   end
endmodule

// ===== sv/srpt_checker.sv =====
// Port-level checks on the response channel, bound to the top level.
// Depends on sinusoidal_rigid_point_transform and srpt_ifs.
module srpt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_pos_x,
   input logic [31:0] rsp_pos_y,
   input logic [31:0] rsp_pos_z,
   input logic [31:0] rsp_angle
);
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_angle) && $stable(rsp_pos_x))
      else $error("response changed while stalled");

   a_angle_from_time: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_valid) && rsp_valid && rsp_angle != $past(rsp_angle)
      |-> rsp_pos_x == 32'd0 && rsp_pos_y == 32'd0 && rsp_pos_z == 32'd0)
      else $error("angle changed on a point response");
endmodule

bind sinusoidal_rigid_point_transform srpt_checker u_srpt_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready),
   .rsp_pos_x(rsp_chan.pos_x), .rsp_pos_y(rsp_chan.pos_y),
   .rsp_pos_z(rsp_chan.pos_z), .rsp_angle(rsp_chan.angle)
);

// ===== dv/tb_srpt_scoreboard.sv =====
// Scoreboard class for the sinusoidal rigid point transform testbench.
// Depends on srpt_pkg; holds the fixed-point predictor and the queue of expected words.
package tb_srpt_scoreboard_pkg;
   import srpt_pkg::*;

   typedef struct packed {
      logic signed [31:0] pos_x, pos_y, pos_z, angle, shift_x, shift_y;
   } motion_word_t;

   class motion_scoreboard;
      // register copies
      longint unsigned rot_amp, rot_freq, trans_amp, trans_freq;
      longint unsigned dir_xy, org_xy, phases, ramp_on;
      // kept motion
      longint held_angle, held_cos, held_sin, held_sx, held_sy;
      motion_word_t pending[$];
      int mismatches;

      function new();
         mismatches = 0;
         reset_state();
      endfunction

      function void reset_state();
         rot_amp = 0; rot_freq = 65536; trans_amp = 0; trans_freq = 65536;
         dir_xy = 64'd1073741824; org_xy = 0; phases = 0; ramp_on = 0;
         held_angle = 0; held_cos = 64'sd1 << 30; held_sin = 0; held_sx = 0; held_sy = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [63:0] val);
         case (idx)
            CSR_ROT_AMPLITUDE:   rot_amp = val[17:0];
            CSR_ROT_FREQUENCY:   rot_freq = val[31:0];
            CSR_TRANS_AMPLITUDE: trans_amp = val[30:0];
            CSR_TRANS_FREQUENCY: trans_freq = val[31:0];
            CSR_DIRECTION_XY:    dir_xy = val;
            CSR_ORIGIN_XY:       org_xy = val;
            CSR_PHASE_PAIR:      phases = val[31:0];
            CSR_SMOOTH_START:    ramp_on = val[0];
            default: ;
         endcase
      endfunction

      static function longint low32s(longint unsigned v);
         logic signed [31:0] w;
         w = v[31:0];
         return longint'(w);
      endfunction

      static function longint mulq30(longint a, longint b);
         return (a * b + (64'sd1 << 29)) >>> 30;
      endfunction

      static function longint clip32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      static function longint clip_unit(longint v);
         if (v > (64'sd1 << 30)) return 64'sd1 << 30;
         if (v < -(64'sd1 << 30)) return -(64'sd1 << 30);
         return v;
      endfunction

      // cos/sin in Q2.30 of a Q0.32 turn
      static function void turn_sincos(logic [31:0] ph, output longint c, output longint s);
         longint z, x, y, dx, dy;
         bit flip;
         z = low32s(ph); flip = 0; x = 652032874; y = 0;
         if (z > (64'sd1 << 30) || z < -(64'sd1 << 30)) begin
            z = low32s(ph ^ 32'h8000_0000); flip = 1;
         end
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> (i % 32); dy = x >>> (i % 32);
            if (z >= 0) begin
               x -= dx; y += dy; z -= longint'(ATAN_TURNS[i % 32]);
            end else begin
               x += dx; y -= dy; z += longint'(ATAN_TURNS[i % 32]);
            end
         end
         x = clip_unit(x); y = clip_unit(y);
         c = flip ? -x : x; s = flip ? -y : y;
      endfunction

      // fractional turn of f*t and the start-up ramp
      function logic [31:0] cycle_frac(longint unsigned f, longint unsigned t,
                                       output longint ramp);
         longint unsigned prod;
         logic [31:0] frac;
         longint c, s;
         prod = f * t;
         frac = prod[31:0];
         ramp = 64'sd1 << 30;
         if (ramp_on != 0 && prod[63:32] == 0) begin
            turn_sincos(frac >> 1, c, s);
            ramp = ((64'sd1 << 30) - c) >>> 1;
         end
         return frac;
      endfunction

      function void note_word(logic mode, logic [31:0] tv, logic signed [31:0] px,
                              logic signed [31:0] py, logic signed [31:0] pz);
         motion_word_t w;
         longint ramp, c, s, mag, ox, oy, dx, dy, rx, ry;
         logic [31:0] fr, pht, phe, turn;
         w.pos_x = 0; w.pos_y = 0; w.pos_z = 0;
         if (mode == KIND_TIME) begin
            pht = {phases[15:0], 16'h0};
            phe = {phases[31:16], 16'h0};
            fr = cycle_frac(rot_freq, tv, ramp);
            turn_sincos(fr + pht + phe, c, s);
            held_angle = clip32(mulq30(mulq30(longint'(rot_amp), s), ramp));
            turn = 32'((held_angle * 683565276) >>> FRAC_BITS);
            turn_sincos(turn, held_cos, held_sin);
            fr = cycle_frac(trans_freq, tv, ramp);
            turn_sincos(fr + pht, c, s);
            mag = mulq30(mulq30(longint'(trans_amp), s), ramp);
            held_sx = clip32(mulq30(mag, low32s(dir_xy)));
            held_sy = clip32(mulq30(mag, low32s(dir_xy >> 32)));
         end else begin
            ox = low32s(org_xy); oy = low32s(org_xy >> 32);
            dx = longint'(px) - ox; dy = longint'(py) - oy;
            rx = (held_cos * dx - held_sin * dy + (64'sd1 << 29)) >>> 30;
            ry = (held_sin * dx + held_cos * dy + (64'sd1 << 29)) >>> 30;
            w.pos_x = 32'(clip32(rx + ox + held_sx));
            w.pos_y = 32'(clip32(ry + oy + held_sy));
            w.pos_z = pz;
         end
         w.angle = 32'(held_angle); w.shift_x = 32'(held_sx); w.shift_y = 32'(held_sy);
         pending.push_back(w);
      endfunction

      function void check_word(motion_word_t got);
         motion_word_t e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response word");
            return;
         end
         e = pending.pop_front();
         if (got != e) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch exp %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
                  e.pos_x, e.pos_y, e.pos_z, e.angle, e.shift_x, e.shift_y,
                  got.pos_x, got.pos_y, got.pos_z, got.angle, got.shift_x, got.shift_y);
         end
      endfunction
   endclass
endpackage

// ===== dv/tb_top.sv =====
// Top of the sinusoidal rigid point transform testbench: clock, reset, stimulus, checks.
// Depends on srpt_pkg, srpt_ifs, tb_srpt_scoreboard_pkg and the RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import srpt_pkg::*;
   import tb_srpt_scoreboard_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic clock = 0, reset = 1;
   logic        csr_write_enable = 0;
   logic [2:0]  csr_index = 0;
   logic [63:0] csr_write_data = 0;
   int          idle_cycles = 0;

   srpt_req_if req_chan();
   srpt_rsp_if rsp_chan();

   motion_scoreboard board = new();

   sinusoidal_rigid_point_transform u_top (
      .clock, .reset, .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_write_enable, .csr_index, .csr_write_data
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   initial begin
      req_chan.valid = 0; req_chan.mode = 0; req_chan.time_value = 0;
      req_chan.point_x = 0; req_chan.point_y = 0; req_chan.point_z = 0;
      rsp_chan.ready = 0;
   end

   // note accepted words and check response words at each edge
   always @(posedge clock) begin
      motion_word_t got;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            board.note_word(req_chan.mode, req_chan.time_value, req_chan.point_x,
                            req_chan.point_y, req_chan.point_z);
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.pos_x = rsp_chan.pos_x; got.pos_y = rsp_chan.pos_y;
            got.pos_z = rsp_chan.pos_z; got.angle = rsp_chan.angle;
            got.shift_x = rsp_chan.shift_x; got.shift_y = rsp_chan.shift_y;
            board.check_word(got);
         end
      end
   end

   // receiver stalls in a pattern of its own: runs of ready, runs of stall
   initial begin
      int run;
      @(posedge clock iff !reset);
      forever begin
         run = $urandom_range(1, 40);
         rsp_chan.ready <= ($urandom_range(0, 3) != 0);
         repeat (run) @(posedge clock);
      end
   end

   // watchdog: advance on cycles with no accepted word
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic write_csr(csr_index_type idx, logic [63:0] val);
      csr_write_enable <= 1; csr_index <= idx; csr_write_data <= val;
      @(posedge clock);
      board.write_reg(idx, val);
      csr_write_enable <= 0;
   endtask

   // hold a word until accepted, leave valid high for the caller to drop
   task automatic send_word(logic mode, logic [31:0] tv, logic [31:0] px,
                            logic [31:0] py, logic [31:0] pz);
      req_chan.valid <= 1; req_chan.mode <= mode; req_chan.time_value <= tv;
      req_chan.point_x <= px; req_chan.point_y <= py; req_chan.point_z <= pz;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic drop_valid();
      req_chan.valid <= 0;
   endtask

   // drain all expected words, then let any time word settle
   task automatic drain();
      drop_valid();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (4 * (CORDIC_STEPS + 2) + 40) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_point();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] rand_time();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 32'h0002_0000);
         1: return $urandom_range(0, 32'h0000_1000);
         default: return $urandom();
      endcase
   endfunction

   // random phase: bursts of mostly points, with time words mixed in at random
   task automatic random_phase(int count);
      int burst, gap, sent;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 30);
         for (int i = 0; i < burst && sent < count; i++, sent++) begin
            if ($urandom_range(0, 5) == 0)
               send_word(KIND_TIME, rand_time(), $urandom(), $urandom(), $urandom());
            else
               send_word(KIND_POINT, $urandom(), rand_point(), rand_point(), rand_point());
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            drop_valid();
            repeat (gap) @(posedge clock);
         end
      end
      drain();
   endtask

   task automatic random_settings(bit extreme);
      write_csr(CSR_ROT_AMPLITUDE, extreme ? 64'd205887 : $urandom_range(0, 205887));
      write_csr(CSR_ROT_FREQUENCY, extreme ? 64'hFFFF_FFFF : $urandom_range(0, 32'h0008_0000));
      write_csr(CSR_TRANS_AMPLITUDE, extreme ? 64'h7FFF_FFFF : {$urandom()} >> 1);
      write_csr(CSR_TRANS_FREQUENCY, extreme ? 64'hFFFF_FFFF : {$urandom()});
      write_csr(CSR_DIRECTION_XY, {$urandom(), $urandom()});
      write_csr(CSR_ORIGIN_XY, {$urandom(), $urandom()});
      write_csr(CSR_PHASE_PAIR, {$urandom()});
      write_csr(CSR_SMOOTH_START, $urandom_range(0, 1));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset defaults, then extremes and special cases
      send_word(KIND_POINT, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      send_word(KIND_TIME, 32'h0000_8000, 32'h1234, 0, 0);
      drain();
      write_csr(CSR_ROT_AMPLITUDE, 64'd205887);
      write_csr(CSR_ROT_FREQUENCY, 64'd0);
      write_csr(CSR_TRANS_AMPLITUDE, 64'h7FFF_FFFF);
      write_csr(CSR_TRANS_FREQUENCY, 64'd0);
      write_csr(CSR_DIRECTION_XY, 64'hC000_0000_4000_0000);
      write_csr(CSR_ORIGIN_XY, 64'h8000_0000_7FFF_FFFF);
      write_csr(CSR_PHASE_PAIR, 64'hFFFF_FFFF);
      write_csr(CSR_SMOOTH_START, 64'd1);
      // zero frequency with ramp on gives zero motion
      send_word(KIND_TIME, 32'hFFFF_FFFF, 0, 0, 0);
      send_word(KIND_POINT, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      drain();
      write_csr(CSR_SMOOTH_START, 64'd0);
      write_csr(CSR_TRANS_FREQUENCY, 64'h0001_0000);
      write_csr(CSR_ROT_FREQUENCY, 64'hFFFF_FFFF);
      // non-unit direction and saturating shift
      write_csr(CSR_DIRECTION_XY, 64'h8000_0000_7FFF_FFFF);
      write_csr(CSR_PHASE_PAIR, 64'h0000_4000);
      send_word(KIND_TIME, 32'h0000_0000, 0, 0, 0);
      send_word(KIND_POINT, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0);
      send_word(KIND_POINT, 0, 0, 0, 32'h7FFF_FFFF);
      send_word(KIND_TIME, 32'hFFFF_FFFF, 0, 0, 0);
      send_word(KIND_POINT, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      drain();

      // random phases across several settings, the extremes among them
      random_settings(1);
      random_phase(150);
      for (int p = 0; p < 5; p++) begin
         random_settings(0);
         random_phase(150);
      end

      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
